// ===== sv/srpg_pkg.sv =====
`timescale 1ns / 1ps
package srpg_pkg;

	// Field and state widths.
	localparam int COUNT_BITS = 23;
	localparam int SPEED_W    = 19;
	localparam int HP_W       = 16;
	localparam int UPD_W      = 18;
	localparam int DVD_W      = 24;
	localparam int DVS_W      = 20;
	localparam int DELTA_W    = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;
	localparam int STEPS_W    = 24;

	// Constants of the speed and timing arithmetic.
	localparam logic [DVD_W-1:0] HALF_US_NUM  = 24'd1000000;
	localparam logic [DVS_W-1:0] MS_DIVISOR   = 20'd1000;
	localparam logic [UPD_W-1:0] TICKS_PER_MS = 18'd1000;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_START_HALF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE     = 3'd4;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD_MAX,
		ST_CMD_CRUISE,
		ST_CMD_START,
		ST_UPD_DELTA,
		ST_UPD_HALF,
		ST_FIN
	} state_t;

	// Saturate a quotient to a half period.
	function automatic logic [HP_W-1:0] sat_half(input logic [DVD_W-1:0] q);
		sat_half = (q[DVD_W-1:HP_W] != '0) ? {HP_W{1'b1}} : q[HP_W-1:0];
	endfunction

	// Twice a speed, a zero speed counting as one.
	function automatic logic [DVS_W-1:0] twice_nz(input logic [SPEED_W-1:0] v);
		logic [SPEED_W-1:0] n;
		n = (v == '0) ? SPEED_W'(1) : v;
		twice_nz = {n, 1'b0};
	endfunction

endpackage

// ===== sv/srpg_in_if.sv =====
`timescale 1ns / 1ps
interface srpg_in_if;
	import srpg_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       func;
	logic signed [STEPS_W-1:0]  target_steps;
	logic                       rotate_mode;

	modport source (output valid, func, target_steps, rotate_mode, input ready);
	modport sink (input valid, func, target_steps, rotate_mode, output ready);
endinterface

// ===== sv/srpg_out_if.sv =====
`timescale 1ns / 1ps
interface srpg_out_if;
	import srpg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  step_out;
	logic                  dir_a;
	logic                  dir_b;
	logic                  busy_res;
	logic [COUNT_BITS-1:0] position;
	logic                  move_done;

	modport source (output valid, step_out, dir_a, dir_b, busy_res, position, move_done,
		input ready);
	modport sink (input valid, step_out, dir_a, dir_b, busy_res, position, move_done,
		output ready);
endinterface

// ===== sv/srpg_div.sv =====
`timescale 1ns / 1ps
module srpg_div
	import srpg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             take;

	// One restoring step: bring down the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		take  = (trial >= {1'b0, dvs_q});
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/stepper_ramp_pulse_generator.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload
// in_ch     sink       func, target_steps, rotate_mode
// out_ch    source     step_out, dir_a, dir_b, busy_res, position, move_done
// cfg       write      cfg_we, cfg_idx, cfg_wdata (no read-back)
//
// A tick that starts no speed update goes from idle straight to the finishing
// state. A tick that updates the speed runs two divisions and a move command
// three, all on the shared restoring divider that every division goes through in
// turn: 24 steps and then a hand-over of the quotient for each division.
// One transaction is worked on at a time; the next is taken once its result
// sits in the output register, which may still be waiting for the sink.
// Reset is asynchronous and leaves the block idle with the default registers.
module stepper_ramp_pulse_generator
	import srpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	srpg_in_if.sink               in_ch,
	srpg_out_if.source            out_ch
);

	// Configuration registers.
	logic [HP_W-1:0]    start_half_q;
	logic [7:0]         interval_q;
	logic [15:0]        accel_q;
	logic [SPEED_W-1:0] max_speed_q;
	logic [SPEED_W-1:0] cruise_q;

	// Move state.
	state_t                state_q, state_d;
	logic                  dir_a_q, dir_b_q;
	logic [COUNT_BITS-1:0] total_q, step_count_q;
	logic [SPEED_W-1:0]    speed_q;
	logic [HP_W-1:0]       half_q, floor_q, half_timer_q;
	logic [UPD_W-1:0]      upd_q;
	logic                  phase_q, running_q;
	logic                  cmd_q, begin_step_q;

	// Output register.
	logic                  out_valid_q;
	logic                  out_step_q, out_busy_q, out_done_q;
	logic                  out_dir_a_q, out_dir_b_q;
	logic [COUNT_BITS-1:0] out_pos_q;

	// Divider connection.
	logic             div_start, div_done;
	logic [DVD_W-1:0] div_dvd, div_quo;
	logic [DVS_W-1:0] div_dvs;

	// Decode of the incoming transaction.
	logic                  accept, slot_free, need_begin, need_update;
	logic [STEPS_W-1:0]    raw, mag;
	logic [COUNT_BITS-1:0] cmd_total;
	logic [UPD_W-1:0]      limit;
	logic [DVD_W-1:0]      prod;
	logic [HP_W-1:0]       start_nz;

	// Speed update and half period.
	logic [DELTA_W-1:0] delta;
	logic [SPEED_W:0]   speed_sum;
	logic [SPEED_W-1:0] speed_new;
	logic [HP_W-1:0]    half_new, half_sat, fin_half;

	// Tick work.
	logic [HP_W-1:0]       pulse_half, ht, ht_dec;
	logic                  ph, ht_zero, step_done, move_end;
	logic [COUNT_BITS-1:0] cnt_inc, step_next;

	srpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign slot_free   = !out_valid_q || out_ch.ready;

	// Decode of a command and of the step start condition.
	always_comb begin
		raw         = in_ch.target_steps;
		mag         = raw[STEPS_W-1] ? (~raw + 1'b1) : raw;
		cmd_total   = mag[STEPS_W-1] ? {COUNT_BITS{1'b1}} : mag[COUNT_BITS-1:0];
		limit       = UPD_W'(interval_q) * TICKS_PER_MS;
		prod        = DVD_W'(accel_q) * DVD_W'(interval_q);
		start_nz    = (start_half_q == '0) ? HP_W'(1) : start_half_q;
		need_begin  = !phase_q && (half_timer_q == '0);
		need_update = running_q && need_begin && (upd_q >= limit);
	end

	// Speed change and the capped half period that follows from it.
	always_comb begin
		delta     = div_quo[DELTA_W-1:0];
		speed_sum = {1'b0, speed_q} + (SPEED_W+1)'(delta);
		if ((total_q >> 1) > step_count_q) begin
			speed_new = speed_sum[SPEED_W] ? {SPEED_W{1'b1}} : speed_sum[SPEED_W-1:0];
		end else if ({1'b0, speed_q} > ((SPEED_W+1)'(delta) + 1'b1)) begin
			speed_new = speed_q - SPEED_W'(delta);
		end else begin
			speed_new = SPEED_W'(1);
		end
		half_sat = sat_half(div_quo);
		half_new = (half_sat > start_nz) ? start_nz : half_sat;
		fin_half = (half_sat < floor_q) ? floor_q : half_sat;
	end

	// Pulse timing of one running tick.
	always_comb begin
		pulse_half = (half_q < floor_q) ? floor_q : half_q;
		if (pulse_half == '0) begin
			pulse_half = HP_W'(1);
		end
		ph        = begin_step_q || phase_q;
		ht        = begin_step_q ? pulse_half : half_timer_q;
		ht_dec    = ht - 1'b1;
		ht_zero   = (ht_dec == '0);
		step_done = ht_zero && !ph;
		cnt_inc   = step_count_q + 1'b1;
		step_next = step_done ? cnt_inc : step_count_q;
		move_end  = step_done && (cnt_inc >= total_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (in_ch.func) state_d = ST_CMD_MAX;
					else if (need_update)   state_d = ST_UPD_DELTA;
					else                    state_d = ST_FIN;
				end
			end
			ST_CMD_MAX:    if (div_done) state_d = ST_CMD_CRUISE;
			ST_CMD_CRUISE: if (div_done) state_d = ST_CMD_START;
			ST_CMD_START:  if (div_done) state_d = ST_FIN;
			ST_UPD_DELTA:  if (div_done) state_d = ST_UPD_HALF;
			ST_UPD_HALF:   if (div_done) state_d = ST_FIN;
			ST_FIN:        if (slot_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Divider requests.
	always_comb begin
		div_start = 1'b0;
		div_dvd   = HALF_US_NUM;
		div_dvs   = MS_DIVISOR;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_ch.func) begin
					div_start = 1'b1;
					div_dvs   = twice_nz(max_speed_q);
				end else if (accept && need_update) begin
					div_start = 1'b1;
					div_dvd   = prod;
				end
			end
			ST_CMD_MAX: begin
				div_start = div_done;
				div_dvs   = twice_nz(cruise_q);
			end
			ST_CMD_CRUISE: begin
				div_start = div_done;
				div_dvs   = twice_nz(SPEED_W'(start_nz));
			end
			ST_UPD_DELTA: begin
				div_start = div_done;
				div_dvs   = twice_nz(speed_new);
			end
			ST_CMD_START, ST_UPD_HALF, ST_FIN: begin
				div_start = 1'b0;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_half_q <= HP_W'(2000);
			interval_q   <= 8'd20;
			accel_q      <= '0;
			max_speed_q  <= SPEED_W'(500000);
			cruise_q     <= SPEED_W'(250);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_START_HALF: start_half_q <= cfg_wdata[HP_W-1:0];
				REG_INTERVAL:   interval_q   <= cfg_wdata[7:0];
				REG_ACCEL:      accel_q      <= cfg_wdata[15:0];
				REG_MAX_SPEED:  max_speed_q  <= cfg_wdata;
				REG_CRUISE:     cruise_q     <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// Sequencer and move state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dir_a_q      <= 1'b0;
			dir_b_q      <= 1'b0;
			total_q      <= '0;
			step_count_q <= '0;
			speed_q      <= '0;
			half_q       <= '0;
			floor_q      <= '0;
			half_timer_q <= '0;
			upd_q        <= '0;
			phase_q      <= 1'b0;
			running_q    <= 1'b0;
			cmd_q        <= 1'b0;
			begin_step_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q        <= in_ch.func;
						begin_step_q <= need_begin;
						if (in_ch.func) begin
							if (raw != '0) begin
								dir_a_q <= !raw[STEPS_W-1];
								dir_b_q <= in_ch.rotate_mode ? !raw[STEPS_W-1]
									: raw[STEPS_W-1];
							end
							total_q      <= cmd_total;
							half_q       <= start_nz;
							step_count_q <= '0;
							half_timer_q <= '0;
							upd_q        <= '0;
							phase_q      <= 1'b0;
							running_q    <= (cmd_total != '0);
						end else if (need_update) begin
							upd_q <= '0;
						end
					end
				end
				ST_CMD_MAX: begin
					if (div_done) floor_q <= half_sat;
				end
				ST_CMD_CRUISE: begin
					if (div_done) floor_q <= fin_half;
				end
				ST_CMD_START: begin
					if (div_done) speed_q <= div_quo[SPEED_W-1:0];
				end
				ST_UPD_DELTA: begin
					if (div_done) speed_q <= speed_new;
				end
				ST_UPD_HALF: begin
					if (div_done) half_q <= half_new;
				end
				ST_FIN: begin
					if (slot_free && !cmd_q && running_q) begin
						phase_q      <= (ht_zero && ph) ? 1'b0 : ph;
						half_timer_q <= (ht_zero && ph) ? pulse_half : ht_dec;
						step_count_q <= move_end ? '0 : step_next;
						running_q    <= !move_end;
						if (upd_q != {UPD_W{1'b1}}) begin
							upd_q <= upd_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Output register: a result waits here until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready) out_valid_q <= 1'b0;
			if (state_q == ST_FIN && slot_free) out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && slot_free) begin
			out_dir_a_q <= dir_a_q;
			out_dir_b_q <= dir_b_q;
			priority if (cmd_q) begin
				out_step_q <= 1'b0;
				out_busy_q <= running_q;
				out_pos_q  <= '0;
				out_done_q <= 1'b0;
			end else if (running_q) begin
				out_step_q <= ph;
				out_busy_q <= !move_end;
				out_pos_q  <= step_next;
				out_done_q <= move_end;
			end else begin
				out_step_q <= 1'b0;
				out_busy_q <= 1'b0;
				out_pos_q  <= step_count_q;
				out_done_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.step_out  = out_step_q;
	assign out_ch.dir_a     = out_dir_a_q;
	assign out_ch.dir_b     = out_dir_b_q;
	assign out_ch.busy_res  = out_busy_q;
	assign out_ch.position  = out_pos_q;
	assign out_ch.move_done = out_done_q;

endmodule
